FILE: src/pba_pkg.sv
package pba_pkg;

    localparam int PTR_W = 18;

    typedef enum logic [2:0] {
        FUNC_RESERVE  = 3'd0,
        FUNC_FREE     = 3'd1,
        FUNC_ALLOC    = 3'd2,
        FUNC_QUERY    = 3'd3,
        FUNC_RSV_RUN  = 3'd4,
        FUNC_FREE_RUN = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_OUT_OF_RANGE = 3'd1,
        STAT_ALREADY_RSV  = 3'd2,
        STAT_ALREADY_FREE = 3'd3,
        STAT_NO_FREE      = 3'd4,
        STAT_NOT_FOUND    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_PRIME,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MODE_RSV_CHK,
        MODE_RSV_COM,
        MODE_FREE,
        MODE_ALLOC,
        MODE_QUERY
    } mode_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] page_index;
        logic [16:0] page_run;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_page;
        logic        page_is_free;
        logic [16:0] free_pages;
    } out_t;

endpackage

FILE: src/pba_ram.sv
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/page_bitmap_allocator.sv
// Channel   Ports                        Word
// input     s_valid s_ready s_data       pba_pkg::in_t  (func, page_index, page_run)
// result    m_valid m_ready m_data       pba_pkg::out_t (status, found_page, ...)
// config    cfg_valid cfg_ready cfg_data page_limit, always ready
//
// Single-page operations make one map pass, reserve-page two (check pass, commit pass).
// Runs and allocation stream one bitmap word per cycle through the map RAM read port;
// a reserve run makes a check pass and then a commit pass over its words.
// After reset a clearing pass writes all ones into the map, one word per cycle over
// all MAP_WORDS words, with s_ready low.
// One item is in work at a time; a new one is taken while the previous result waits on m_ready.
module page_bitmap_allocator #(
    parameter int MAX_PAGES = 65536,
    parameter int WORD_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pba_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pba_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [16:0]   cfg_data
);

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int NW        = BW + 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int CW        = (CNT_W > 17) ? CNT_W : 17;
    localparam int XW        = (AW > 16) ? AW : 16;
    localparam int SH        = 24;
    localparam int RECIP     = (1 << SH) / WORD_BITS;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int PRW       = 16 + RW;
    localparam int PW        = pba_pkg::PTR_W;

    pba_pkg::state_t  state_reg, state_next;
    pba_pkg::mode_t   mode_reg, mode_next;
    pba_pkg::status_t status_reg, status_next;
    pba_pkg::out_t    out_reg, out_next;

    logic             m_valid_reg, m_valid_next;
    logic             single_reg, single_next;
    logic [16:0]      page_limit_reg, page_limit_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [15:0]      idx_reg, idx_next;
    logic [16:0]      run_reg, run_next;
    logic [XW-1:0]    q_reg, q_next;
    logic [AW-1:0]    start_word_reg, start_word_next;
    logic [BW-1:0]    start_off_reg, start_off_next;
    logic [PW-1:0]    start_base_reg, start_base_next;
    logic [AW-1:0]    cur_word_reg, cur_word_next;
    logic [BW-1:0]    cur_off_reg, cur_off_next;
    logic [PW-1:0]    cur_base_reg, cur_base_next;
    logic [16:0]      rem_reg, rem_next;
    logic [15:0]      found_reg, found_next;
    logic             is_free_reg, is_free_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] rd;

    logic [16:0]          lim;
    logic [PRW-1:0]       prod;
    logic [XW-1:0]        r_raw;
    logic [XW-1:0]        r_fix;
    logic [XW-1:0]        q_fix;
    logic [NW-1:0]        avail;
    logic [NW-1:0]        n;
    logic [NW-1:0]        chunk_end;
    logic [PW-1:0]        lim_rem;
    logic                 base_lt;
    logic                 lim_big;
    logic [WORD_BITS-1:0] chunk;
    logic [WORD_BITS-1:0] inr;
    logic [WORD_BITS-1:0] clr;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] low;
    logic [BW-1:0]        low_idx;
    logic                 rsv_hit;
    logic                 oor_hit;
    logic                 rem_zero;

    pba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd)
    );

    assign s_ready   = (state_reg == pba_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign lim = (32'(page_limit_reg) > 32'(MAX_PAGES)) ? 17'(MAX_PAGES) : page_limit_reg;

    assign prod  = PRW'(idx_reg) * PRW'(RECIP);
    assign r_raw = XW'(idx_reg) - XW'(q_reg * XW'(WORD_BITS));
    assign q_fix = (r_raw >= XW'(WORD_BITS)) ? q_reg + XW'(1) : q_reg;
    assign r_fix = (r_raw >= XW'(WORD_BITS)) ? r_raw - XW'(WORD_BITS) : r_raw;

    always_comb begin
        avail     = NW'(WORD_BITS) - NW'(cur_off_reg);
        n         = (rem_reg >= 17'(avail)) ? avail : rem_reg[NW-1:0];
        chunk_end = NW'(cur_off_reg) + n;
        base_lt   = cur_base_reg < PW'(lim);
        lim_rem   = PW'(lim) - cur_base_reg;
        lim_big   = lim_rem >= PW'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++) begin
            chunk[b] = (NW'(b) >= NW'(cur_off_reg)) && (NW'(b) < chunk_end);
            inr[b]   = base_lt && (lim_big || (NW'(b) < lim_rem[NW-1:0]));
        end
        clr      = rd & chunk & inr;
        rsv_hit  = |clr;
        oor_hit  = |(chunk & ~inr);
        cand     = ~rd & inr;
        low      = cand & (~cand + WORD_BITS'(1));
        low_idx  = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (low[b]) begin
                low_idx = low_idx | BW'(b);
            end
        end
        rem_zero = (rem_reg == 17'd0);
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        status_next     = status_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        single_next     = single_reg;
        page_limit_next = cfg_valid ? cfg_data : page_limit_reg;
        count_next      = count_reg;
        clr_cnt_next    = clr_cnt_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        q_next          = q_reg;
        start_word_next = start_word_reg;
        start_off_next  = start_off_reg;
        start_base_next = start_base_reg;
        cur_word_next   = cur_word_reg;
        cur_off_next    = cur_off_reg;
        cur_base_next   = cur_base_reg;
        rem_next        = rem_reg;
        found_next      = found_reg;
        is_free_next    = is_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_word_reg;
        ram_wdata       = rd;
        ram_raddr       = cur_word_reg + AW'(1);

        unique case (state_reg)
            pba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '1;
                if (clr_cnt_reg == AW'(MAP_WORDS - 1)) begin
                    state_next = pba_pkg::ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            pba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    idx_next     = s_data.page_index;
                    run_next     = 17'd1;
                    status_next  = pba_pkg::STAT_OK;
                    found_next   = '0;
                    is_free_next = 1'b0;
                    single_next  = 1'b0;
                    state_next   = pba_pkg::ST_DIV_MUL;
                    unique case (s_data.func)
                        pba_pkg::FUNC_RESERVE: begin
                            mode_next = pba_pkg::MODE_RSV_CHK;
                        end
                        pba_pkg::FUNC_FREE: begin
                            mode_next   = pba_pkg::MODE_FREE;
                            single_next = 1'b1;
                        end
                        pba_pkg::FUNC_ALLOC: begin
                            mode_next = pba_pkg::MODE_ALLOC;
                            idx_next  = '0;
                            if (count_reg == '0) begin
                                status_next = pba_pkg::STAT_NO_FREE;
                                state_next  = pba_pkg::ST_DONE;
                            end
                        end
                        pba_pkg::FUNC_QUERY: begin
                            mode_next = pba_pkg::MODE_QUERY;
                        end
                        pba_pkg::FUNC_RSV_RUN: begin
                            mode_next = pba_pkg::MODE_RSV_CHK;
                            run_next  = s_data.page_run;
                        end
                        pba_pkg::FUNC_FREE_RUN: begin
                            mode_next = pba_pkg::MODE_FREE;
                            run_next  = s_data.page_run;
                        end
                        default: begin
                            state_next = pba_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pba_pkg::ST_DIV_MUL: begin
                q_next     = XW'(prod >> SH);
                state_next = pba_pkg::ST_DIV_FIX;
            end
            pba_pkg::ST_DIV_FIX: begin
                start_word_next = q_fix[AW-1:0];
                start_off_next  = r_fix[BW-1:0];
                start_base_next = PW'(idx_reg) - PW'(r_fix);
                state_next      = pba_pkg::ST_PRIME;
            end
            pba_pkg::ST_PRIME: begin
                ram_raddr     = start_word_reg;
                cur_word_next = start_word_reg;
                cur_off_next  = start_off_reg;
                cur_base_next = start_base_reg;
                rem_next      = run_reg;
                state_next    = pba_pkg::ST_SCAN;
            end
            pba_pkg::ST_SCAN: begin
                cur_word_next = cur_word_reg + AW'(1);
                cur_off_next  = '0;
                cur_base_next = cur_base_reg + PW'(WORD_BITS);
                rem_next      = rem_reg - 17'(n);
                unique case (mode_reg)
                    pba_pkg::MODE_RSV_CHK: begin
                        if (rem_zero) begin
                            mode_next  = pba_pkg::MODE_RSV_COM;
                            state_next = pba_pkg::ST_PRIME;
                        end else if (rsv_hit) begin
                            status_next = pba_pkg::STAT_ALREADY_RSV;
                            state_next  = pba_pkg::ST_DONE;
                        end else if (oor_hit) begin
                            status_next = pba_pkg::STAT_OUT_OF_RANGE;
                            state_next  = pba_pkg::ST_DONE;
                        end
                    end
                    pba_pkg::MODE_RSV_COM: begin
                        if (rem_zero) begin
                            state_next = pba_pkg::ST_DONE;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = rd | chunk;
                            count_next = count_reg - CW'(n);
                        end
                    end
                    pba_pkg::MODE_FREE: begin
                        if (rem_zero) begin
                            state_next = pba_pkg::ST_DONE;
                        end else begin
                            ram_we     = rsv_hit;
                            ram_wdata  = rd & ~clr;
                            count_next = count_reg + CW'($countones(clr));
                            if (oor_hit) begin
                                status_next = pba_pkg::STAT_OUT_OF_RANGE;
                                state_next  = pba_pkg::ST_DONE;
                            end else if (single_reg && !rsv_hit) begin
                                status_next = pba_pkg::STAT_ALREADY_FREE;
                                state_next  = pba_pkg::ST_DONE;
                            end
                        end
                    end
                    pba_pkg::MODE_ALLOC: begin
                        if (!base_lt) begin
                            status_next = pba_pkg::STAT_NOT_FOUND;
                            state_next  = pba_pkg::ST_DONE;
                        end else if (|cand) begin
                            ram_we     = 1'b1;
                            ram_wdata  = rd | low;
                            count_next = count_reg - CW'(1);
                            found_next = 16'(cur_base_reg + PW'(low_idx));
                            state_next = pba_pkg::ST_DONE;
                        end
                    end
                    pba_pkg::MODE_QUERY: begin
                        if (oor_hit) begin
                            status_next = pba_pkg::STAT_OUT_OF_RANGE;
                        end else begin
                            is_free_next = |(~rd & chunk);
                        end
                        state_next = pba_pkg::ST_DONE;
                    end
                    default: begin
                        state_next = pba_pkg::ST_DONE;
                    end
                endcase
            end
            pba_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.status       = status_reg;
                    out_next.found_page   = found_reg;
                    out_next.page_is_free = is_free_reg;
                    out_next.free_pages   = count_reg[16:0];
                    m_valid_next          = 1'b1;
                    state_next            = pba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pba_pkg::ST_CLEAR;
            mode_reg       <= pba_pkg::MODE_QUERY;
            m_valid_reg    <= 1'b0;
            single_reg     <= 1'b0;
            page_limit_reg <= 17'h10000;
            count_reg      <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            m_valid_reg    <= m_valid_next;
            single_reg     <= single_next;
            page_limit_reg <= page_limit_next;
            count_reg      <= count_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        out_reg        <= out_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        q_reg          <= q_next;
        start_word_reg <= start_word_next;
        start_off_reg  <= start_off_next;
        start_base_reg <= start_base_next;
        cur_word_reg   <= cur_word_next;
        cur_off_reg    <= cur_off_next;
        cur_base_reg   <= cur_base_next;
        rem_reg        <= rem_next;
        found_reg      <= found_next;
        is_free_reg    <= is_free_next;
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != pba_pkg::ST_IDLE)
        else $error("accepted word did not start work");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(MAX_PAGES))
        else $error("free count above page total");

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == pba_pkg::ST_CLEAR || state_reg == pba_pkg::ST_SCAN)
        else $error("map write outside clear or scan");

    a_alloc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pba_pkg::ST_DONE && mode_reg == pba_pkg::MODE_ALLOC
        && status_reg == pba_pkg::STAT_OK |-> 17'(found_reg) < lim)
        else $error("allocated page beyond limit");

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_PAGES = 65536;
    localparam logic [2:0] FUNC_UNDEF_LO = 3'd6;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    pba_pkg::in_t  s_data    = '0;
    logic          m_ready   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [16:0]   cfg_data  = '0;
    logic          s_ready;
    logic          m_valid;
    logic          cfg_ready;
    pba_pkg::out_t m_data;

    bit            page_reserved [NUM_PAGES];
    int unsigned   free_count;
    int unsigned   page_limit;
    pba_pkg::out_t expected_results [$];
    int            error_count = 0;
    bit            idle_on = 1'b1;
    int            stall_left = 0;

    page_bitmap_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic pba_pkg::status_t reserve_page(int unsigned p, int unsigned lim);
        if (p >= lim) return pba_pkg::STAT_OUT_OF_RANGE;
        if (page_reserved[p]) return pba_pkg::STAT_ALREADY_RSV;
        page_reserved[p] = 1'b1;
        if (free_count > 0) free_count--;
        return pba_pkg::STAT_OK;
    endfunction

    function automatic pba_pkg::status_t free_page(int unsigned p, int unsigned lim);
        if (p >= lim) return pba_pkg::STAT_OUT_OF_RANGE;
        if (!page_reserved[p]) return pba_pkg::STAT_ALREADY_FREE;
        page_reserved[p] = 1'b0;
        free_count++;
        return pba_pkg::STAT_OK;
    endfunction

    function automatic pba_pkg::out_t apply_op(pba_pkg::in_t w);
        pba_pkg::out_t    r;
        pba_pkg::status_t st;
        int unsigned      lim;
        int unsigned      p;
        int unsigned      i;
        r   = '0;
        st  = pba_pkg::STAT_OK;
        lim = (page_limit > NUM_PAGES) ? NUM_PAGES : page_limit;
        case (w.func)
            pba_pkg::FUNC_RESERVE: st = reserve_page(w.page_index, lim);
            pba_pkg::FUNC_FREE:    st = free_page(w.page_index, lim);
            pba_pkg::FUNC_ALLOC: begin
                if (free_count == 0) begin
                    st = pba_pkg::STAT_NO_FREE;
                end else begin
                    st = pba_pkg::STAT_NOT_FOUND;
                    for (p = 0; p < lim; p++) begin
                        if (!page_reserved[p]) begin
                            void'(reserve_page(p, lim));
                            r.found_page = p[15:0];
                            st = pba_pkg::STAT_OK;
                            break;
                        end
                    end
                end
            end
            pba_pkg::FUNC_QUERY: begin
                if (w.page_index >= lim) st = pba_pkg::STAT_OUT_OF_RANGE;
                else r.page_is_free = !page_reserved[w.page_index];
            end
            pba_pkg::FUNC_RSV_RUN: begin
                for (i = 0; i < w.page_run; i++) begin
                    p = w.page_index + i;
                    if (p >= lim) begin
                        st = pba_pkg::STAT_OUT_OF_RANGE;
                        break;
                    end
                    if (page_reserved[p]) begin
                        st = pba_pkg::STAT_ALREADY_RSV;
                        break;
                    end
                end
                if (st == pba_pkg::STAT_OK) begin
                    for (i = 0; i < w.page_run; i++) begin
                        void'(reserve_page(w.page_index + i, lim));
                    end
                end
            end
            pba_pkg::FUNC_FREE_RUN: begin
                for (i = 0; i < w.page_run; i++) begin
                    p = w.page_index + i;
                    if (p >= lim) begin
                        st = pba_pkg::STAT_OUT_OF_RANGE;
                        break;
                    end
                    void'(free_page(p, lim));
                end
            end
            default: ;
        endcase
        r.status     = st;
        r.free_pages = free_count[16:0];
        return r;
    endfunction

    function automatic pba_pkg::in_t make_word(logic [2:0] f, int unsigned idx, int unsigned run);
        pba_pkg::in_t w;
        w.func       = f;
        w.page_index = idx[15:0];
        w.page_run   = run[16:0];
        return w;
    endfunction

    function automatic pba_pkg::in_t random_word();
        int unsigned eff;
        int unsigned hi;
        int unsigned lo;
        int unsigned sel;
        int unsigned idx;
        int unsigned run;
        logic [2:0]  f;
        eff = (page_limit > NUM_PAGES) ? NUM_PAGES : page_limit;
        hi  = (eff + 8 > NUM_PAGES - 1) ? NUM_PAGES - 1 : eff + 8;
        lo  = (eff > 40) ? eff - 40 : 0;
        sel = $urandom_range(0, 99);
        if (sel < 20)      f = pba_pkg::FUNC_RESERVE;
        else if (sel < 42) f = pba_pkg::FUNC_FREE;
        else if (sel < 56) f = pba_pkg::FUNC_ALLOC;
        else if (sel < 68) f = pba_pkg::FUNC_QUERY;
        else if (sel < 83) f = pba_pkg::FUNC_RSV_RUN;
        else if (sel < 98) f = pba_pkg::FUNC_FREE_RUN;
        else if (sel < 99) f = FUNC_UNDEF_LO;
        else               f = FUNC_UNDEF_HI;
        sel = $urandom_range(0, 99);
        if (sel < 70)      idx = $urandom_range(0, (hi < 1023) ? hi : 1023);
        else if (sel < 85) idx = $urandom_range(lo, hi);
        else               idx = $urandom_range(0, NUM_PAGES - 1);
        sel = $urandom_range(0, 99);
        if (sel < 85)      run = $urandom_range(0, 80);
        else if (sel < 96) run = $urandom_range(0, 700);
        else if (sel < 98) run = $urandom_range(0, NUM_PAGES);
        else               run = NUM_PAGES;
        return make_word(f, idx, run);
    endfunction

    task automatic send_word(pba_pkg::in_t w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_op(w));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_page_limit(int unsigned value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value[16:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        page_limit = value & 32'h1FFFF;
    endtask

    task automatic test_reset_state();
        send_word(make_word(pba_pkg::FUNC_ALLOC, 0, 0));
        send_word(make_word(pba_pkg::FUNC_QUERY, 0, 0));
        send_word(make_word(pba_pkg::FUNC_FREE, 65535, 0));
        send_word(make_word(pba_pkg::FUNC_FREE, 65535, 0));
        send_word(make_word(pba_pkg::FUNC_RESERVE, 0, 0));
    endtask

    task automatic test_page_runs();
        send_word(make_word(pba_pkg::FUNC_FREE_RUN, 0, 0));
        send_word(make_word(pba_pkg::FUNC_RSV_RUN, 100, 0));
        send_word(make_word(pba_pkg::FUNC_FREE_RUN, 65530, NUM_PAGES));
        send_word(make_word(pba_pkg::FUNC_RSV_RUN, 65530, 7));
        send_word(make_word(pba_pkg::FUNC_RSV_RUN, 65530, 6));
        send_word(make_word(pba_pkg::FUNC_ALLOC, 0, 0));
        send_word(make_word(pba_pkg::FUNC_FREE, 200, 0));
    endtask

    task automatic test_limit_edges();
        write_page_limit(64);
        send_word(make_word(pba_pkg::FUNC_ALLOC, 0, 0));
        send_word(make_word(pba_pkg::FUNC_RESERVE, 64, 0));
        send_word(make_word(pba_pkg::FUNC_FREE, 64, 0));
        send_word(make_word(pba_pkg::FUNC_QUERY, 64, 0));
        send_word(make_word(pba_pkg::FUNC_FREE_RUN, 60, 10));
        send_word(make_word(pba_pkg::FUNC_ALLOC, 0, 0));
        send_word(make_word(pba_pkg::FUNC_RSV_RUN, 61, 2));
        send_word(make_word(pba_pkg::FUNC_RSV_RUN, 60, 2));
        write_page_limit(0);
        send_word(make_word(pba_pkg::FUNC_ALLOC, 0, 0));
        send_word(make_word(pba_pkg::FUNC_QUERY, 0, 0));
        write_page_limit(131071);
        send_word(make_word(pba_pkg::FUNC_QUERY, 65535, 0));
    endtask

    task automatic test_undefined_func();
        send_word(make_word(FUNC_UNDEF_LO, 65535, NUM_PAGES));
        send_word(make_word(FUNC_UNDEF_HI, 0, 0));
    endtask

    task automatic test_random_traffic();
        int unsigned phase_limits [8];
        phase_limits = '{65536, 4096, 1000, 1, 333, 131071, 65535, 64};
        for (int k = 0; k < 8; k++) begin
            write_page_limit(phase_limits[k]);
            idle_on = (k != 7) && ($urandom_range(0, 3) != 0);
            repeat (250) send_word(random_word());
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_result
        pba_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with none expected");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.found_page !== want.found_page) begin
                    $error("found_page: expected %0d, actual %0d",
                           want.found_page, m_data.found_page);
                    error_count++;
                end
                if (m_data.page_is_free !== want.page_is_free) begin
                    $error("page_is_free: expected %0d, actual %0d",
                           want.page_is_free, m_data.page_is_free);
                    error_count++;
                end
                if (m_data.free_pages !== want.free_pages) begin
                    $error("free_pages: expected %0d, actual %0d",
                           want.free_pages, m_data.free_pages);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (page_reserved[p]) page_reserved[p] = 1'b1;
        free_count = 0;
        page_limit = NUM_PAGES;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_page_runs();
        test_limit_edges();
        test_undefined_func();
        test_random_traffic();
        drain_results();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
